// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the slot allocator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define DSA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("dsa assertion failed");

// A condition that must hold at an edge where the antecedent holds.
`define DSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsa assertion failed");

`endif

// ----- hw/rtl/dsa_pkg.sv -----
// Shared types and constants for the deadline slot allocator.
// Used by dsa_ctrl, dsa_datapath and the top level; no dependencies.
package dsa_pkg;

  localparam int MaxSlotsDef   = 256;
  localparam int ResetSlots    = 256;
  localparam int JobIdW        = 16;
  localparam int DeadlineW     = 9;
  localparam int SlotW         = 9;
  localparam int CfgW          = 9;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_CP_CHK,
    S_CP_RD,
    S_CP_WR,
    S_JOIN_A,
    S_JOIN_B,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_START,
    OP_READ,
    OP_HOP,
    OP_ROOT,
    OP_CP_WR,
    OP_NEXT,
    OP_JOIN_A,
    OP_JOIN_B,
    OP_FINISH
  } op_e;

  typedef struct packed {
    logic full;
    logic is_root;
    logic at_root;
    logic same_root;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/dsa_ctrl.sv -----
// Sequencer for the deadline slot allocator: clearing pass, two finds with
// path collapsing, the union, and result hand-off. Depends on dsa_pkg.
module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    cfg_we_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output op_e     op_o
);

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          phase_d = 1'b0;
          state_d = status_i.full ? S_DONE : S_FIND_RD;
        end
      end
      S_FIND_RD:  state_d = S_FIND_CHK;
      S_FIND_CHK: state_d = status_i.is_root ? S_CP_CHK : S_FIND_RD;
      S_CP_CHK: begin
        if (!status_i.at_root) begin
          state_d = S_CP_RD;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_FIND_RD;
        end else begin
          state_d = status_i.same_root ? S_DONE : S_JOIN_A;
        end
      end
      S_CP_RD:  state_d = S_CP_WR;
      S_CP_WR:  state_d = S_CP_CHK;
      S_JOIN_A: state_d = S_JOIN_B;
      S_JOIN_B: state_d = S_DONE;
      S_DONE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    // A register write restarts the clearing pass.
    if (cfg_we_i) state_d = S_CLEAR;
  end

  // Outputs.
  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: op_o = OP_CLR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_START;
      end
      S_FIND_RD:  op_o = OP_READ;
      S_FIND_CHK: op_o = status_i.is_root ? OP_ROOT : OP_HOP;
      S_CP_CHK: begin
        if (status_i.at_root && !phase_q) op_o = OP_NEXT;
      end
      S_CP_RD:  op_o = OP_READ;
      S_CP_WR:  op_o = OP_CP_WR;
      S_JOIN_A: op_o = OP_JOIN_A;
      S_JOIN_B: op_o = OP_JOIN_B;
      S_DONE: begin
        if (status_i.out_free) op_o = OP_FINISH;
      end
      default: op_o = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/dsa_datapath.sv -----
// Datapath of the deadline slot allocator: union-find store, walk registers,
// union arithmetic and the output register. Depends on dsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dsa_datapath
  import dsa_pkg::*;
#(
  parameter int MAX_SLOTS = MaxSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  op_e                  op_i,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_value_i,
  input  logic [JobIdW-1:0]    job_id_i,
  input  logic [DeadlineW-1:0] deadline_i,
  input  logic                 out_ready_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  output logic [JobIdW-1:0]    job_id_out_o,
  output logic [SlotW-1:0]     slot_o,
  output logic                 late_o,
  output logic                 full_res_o
);

  localparam int SW     = $clog2(MAX_SLOTS + 1);
  localparam int EW     = 1 + 2 * SW;
  localparam int RstSlt = (ResetSlots > MAX_SLOTS) ? MAX_SLOTS : ResetSlots;

  // Entry: {root flag, size when root or parent otherwise, free slot}.
  logic [EW-1:0] mem [MAX_SLOTS + 1];
  logic [EW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [SW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [SW-1:0] slots_q, clr_cnt_q, placed_q;
  logic [SW-1:0] cur_q, start_q, r_q, root_val_q, root_free_q;
  logic [SW-1:0] a_q, a_size_q, a_free_q, s_q, dl_q;
  logic          late_q, full_q;
  logic [JobIdW-1:0] id_q;
  logic          out_valid_q;

  logic          rd_root;
  logic [SW-1:0] rd_val, rd_free, tot;
  logic          a_smaller;
  logic [31:0]   cfg_v, dl_v, s_v, slot_v;

  assign rd_root   = rdata_q[EW-1];
  assign rd_val    = rdata_q[2*SW-1:SW];
  assign rd_free   = rdata_q[SW-1:0];
  assign tot       = a_size_q + root_val_q;
  assign a_smaller = a_size_q < root_val_q;

  always_comb begin
    cfg_v = 32'(cfg_value_i);
    if (cfg_v == 32'd0) cfg_v = 32'd1;
    if (cfg_v > 32'(MAX_SLOTS)) cfg_v = 32'(MAX_SLOTS);
    dl_v = 32'(deadline_i);
    if (dl_v > 32'(slots_q)) dl_v = 32'(slots_q);
    s_v = 32'(root_free_q);
    if (s_v == 32'd0 || s_v > 32'(slots_q)) s_v = 32'(slots_q);
    slot_v = full_q ? 32'd0 : 32'(s_q);
  end

  // Store write port.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cur_q;
    wr_data = {1'b0, r_q, rd_free};
    unique case (op_i)
      OP_CLR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt_q;
        // Node zero links to the last slot, which gives the wrap.
        wr_data = (clr_cnt_q == '0) ? {1'b0, slots_q, {SW{1'b0}}}
                                    : {1'b1, SW'(1), clr_cnt_q};
      end
      OP_CP_WR: mem_we = 1'b1;
      OP_JOIN_A: begin
        mem_we  = 1'b1;
        wr_addr = a_smaller ? a_q : r_q;
        wr_data = a_smaller ? {1'b0, r_q, a_free_q} : {1'b0, a_q, root_free_q};
      end
      OP_JOIN_B: begin
        mem_we  = 1'b1;
        wr_addr = a_smaller ? r_q : a_q;
        wr_data = {1'b1, tot, root_free_q};
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign mem_re = (op_i == OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rdata_q <= mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= SW'(RstSlt);
      clr_cnt_q   <= '0;
      placed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        slots_q   <= cfg_v[SW-1:0];
        clr_cnt_q <= '0;
        placed_q  <= '0;
      end else if (op_i == OP_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        placed_q  <= '0;
      end else if (op_i == OP_FINISH && !full_q) begin
        placed_q <= placed_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_START: begin
        id_q    <= job_id_i;
        full_q  <= placed_q >= slots_q;
        dl_q    <= dl_v[SW-1:0];
        cur_q   <= dl_v[SW-1:0];
        start_q <= dl_v[SW-1:0];
      end
      OP_HOP: cur_q <= rd_val;
      OP_ROOT: begin
        r_q         <= cur_q;
        root_val_q  <= rd_val;
        root_free_q <= rd_free;
        cur_q       <= start_q;
      end
      OP_CP_WR: cur_q <= rd_val;
      OP_NEXT: begin
        a_q      <= r_q;
        a_size_q <= root_val_q;
        a_free_q <= root_free_q;
        s_q      <= s_v[SW-1:0];
        late_q   <= (dl_q != '0) && (s_v[SW-1:0] > dl_q);
        cur_q    <= s_v[SW-1:0] - 1'b1;
        start_q  <= s_v[SW-1:0] - 1'b1;
      end
      OP_FINISH: begin
        job_id_out_o <= id_q;
        slot_o       <= slot_v[SlotW-1:0];
        late_o       <= late_q && !full_q;
        full_res_o   <= full_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.full      = placed_q >= slots_q;
  assign status_o.is_root   = rd_root;
  assign status_o.at_root   = cur_q == r_q;
  assign status_o.same_root = r_q == a_q;
  assign status_o.clr_last  = clr_cnt_q == SW'(MAX_SLOTS);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  `DSA_ASSERT(a_placed_bound, placed_q <= slots_q)
  `DSA_ASSERT_IMP(a_join_distinct, op_i == OP_JOIN_A, r_q != a_q)
  `DSA_ASSERT_IMP(a_full_shape, out_valid_q && full_res_o, slot_o == '0 && !late_o)
  `DSA_ASSERT_IMP(a_placed_slot, out_valid_q && !full_res_o, slot_o != '0)

endmodule

// ----- hw/rtl/deadline_slot_allocator.sv -----
// Deadline slot allocator: places each job, given in order of falling profit, in the
// latest free slot at or before its deadline, wrapping to the latest free slot (late)
// or reporting full. One job is in work at a time. The union is skipped when both
// searches end at the same root, which happens when the job fills the last free set,
// and the searches are skipped too when the schedule is already full. Each parent link
// walked in the two union-find searches is followed and then collapsed, through the
// single read port of the set store. A result that waits on out_ready_i holds the
// block for as long as it waits. After reset and after every slots_in_use write, a
// clearing pass over store entries 0 to MAX_SLOTS runs before jobs are accepted.
// Depends on dsa_pkg and submodules.
module deadline_slot_allocator
  import dsa_pkg::*;
#(
  parameter int MAX_SLOTS = MaxSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgW-1:0]      slots_in_use_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [JobIdW-1:0]    job_id_i,
  input  logic [DeadlineW-1:0] deadline_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [JobIdW-1:0]    job_id_out_o,
  output logic [SlotW-1:0]     slot_o,
  output logic                 late_o,
  output logic                 full_res_o
);

  op_e     op;
  status_t status;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  dsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .op_o       (op)
  );

  dsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .cfg_we_i     (cfg_we),
    .cfg_value_i  (slots_in_use_i),
    .job_id_i     (job_id_i),
    .deadline_i   (deadline_i),
    .out_ready_i  (out_ready_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .job_id_out_o (job_id_out_o),
    .slot_o       (slot_o),
    .late_o       (late_o),
    .full_res_o   (full_res_o)
  );

endmodule

// ----- sim/tb_deadline_slot_allocator.sv -----
// Self-checking testbench for deadline_slot_allocator: random and directed jobs with
// handshake stalls, checked against an in-bench union-find slot predictor.
// Depends on dsa_pkg and the deadline_slot_allocator RTL.
module tb_deadline_slot_allocator;
  import dsa_pkg::*;

  localparam int NSlots = MaxSlotsDef;

  typedef struct packed {
    logic [JobIdW-1:0]    job_id;
    logic [DeadlineW-1:0] deadline;
  } job_t;

  typedef struct packed {
    logic [JobIdW-1:0] job_id;
    logic [SlotW-1:0]  slot;
    logic              late;
    logic              full;
  } place_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] slots_in_use_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [JobIdW-1:0] job_id_i = '0;
  logic [DeadlineW-1:0] deadline_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [JobIdW-1:0] job_id_out_o;
  logic [SlotW-1:0] slot_o;
  logic late_o;
  logic full_res_o;

  always #1 clk_i = ~clk_i;

  deadline_slot_allocator i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .slots_in_use_i,
    .in_valid_i, .in_ready_o, .job_id_i, .deadline_i,
    .out_valid_o, .out_ready_i, .job_id_out_o, .slot_o, .late_o, .full_res_o
  );

  // Predictor state: union-find forest over slots, node zero links to the last slot.
  int unsigned slot_count;
  int          parent_of[NSlots+1];
  int unsigned free_of[NSlots+1];
  int unsigned placed;

  job_t   job_queue[$];
  place_t placement_queue[$];
  int     error_count = 0;
  int     jobs_sent = 0;
  int     results_seen = 0;
  int     full_seen = 0;
  int     late_seen = 0;
  int     hold_off = 0;
  bit     stim_done = 1'b0;

  function automatic void clear_forest(int unsigned n);
    slot_count = (n < 1) ? 1 : ((n > NSlots) ? NSlots : n);
    for (int i = 0; i <= NSlots; i++) begin
      parent_of[i] = -1;
      free_of[i] = i;
    end
    parent_of[0] = slot_count;
    placed = 0;
  endfunction

  function automatic int unsigned find_root(int unsigned x);
    int unsigned r, nxt, steps;
    r = (x > NSlots) ? NSlots : x;
    x = r;
    steps = 0;
    while (parent_of[r] >= 0 && steps <= NSlots + 1) begin
      nxt = parent_of[r];
      if (nxt > NSlots) break;
      r = nxt;
      steps++;
    end
    steps = 0;
    while (x != r && steps <= NSlots + 1) begin
      nxt = parent_of[x];
      parent_of[x] = r;
      if (nxt > NSlots) break;
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic place_t place_job(job_t j);
    place_t p;
    int unsigned d, root, s, left;
    int total;
    p = '0;
    p.job_id = j.job_id;
    if (placed >= slot_count) begin
      p.full = 1'b1;
      return p;
    end
    d = (j.deadline > slot_count) ? slot_count : j.deadline;
    root = find_root(d);
    s = free_of[root];
    if (s < 1 || s > slot_count) s = slot_count;
    p.late = (d != 0) && (s > d);
    left = find_root(s - 1);
    if (left != root) begin
      total = parent_of[root] + parent_of[left];
      if (parent_of[root] > parent_of[left]) begin
        parent_of[root] = left;
        parent_of[left] = total;
      end else begin
        parent_of[left] = root;
        parent_of[root] = total;
        free_of[root] = free_of[left];
      end
    end
    placed++;
    p.slot = SlotW'(s);
    return p;
  endfunction

  // Driver: one beat at a time from the job queue, with a random gap after each.
  int gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      placement_queue.push_back(place_job('{job_id_i, deadline_i}));
      jobs_sent++;
    end
    if (in_valid_i && !in_ready_o) begin
      // Holding the beat.
    end else if (gap > 0) begin
      in_valid_i <= 1'b0;
      gap <= gap - 1;
    end else if (job_queue.size() > 0) begin
      job_t j;
      j = job_queue.pop_front();
      in_valid_i <= 1'b1;
      job_id_i <= j.job_id;
      deadline_i <= j.deadline;
      gap <= $urandom_range(0, 8) * ($urandom_range(0, 3) == 0 ? 0 : 1);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: checks each result beat and draws the receiver's stall.
  int stall = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      place_t exp_p;
      results_seen++;
      if (placement_queue.size() == 0) begin
        $error("result with no job pending: id %0d", job_id_out_o);
        error_count++;
      end else begin
        exp_p = placement_queue.pop_front();
        if (job_id_out_o !== exp_p.job_id) begin
          $error("job_id_out expected %0d got %0d", exp_p.job_id, job_id_out_o);
          error_count++;
        end
        if (slot_o !== exp_p.slot) begin
          $error("slot expected %0d got %0d", exp_p.slot, slot_o);
          error_count++;
        end
        if (late_o !== exp_p.late) begin
          $error("late expected %0d got %0d", exp_p.late, late_o);
          error_count++;
        end
        if (full_res_o !== exp_p.full) begin
          $error("full_res expected %0d got %0d", exp_p.full, full_res_o);
          error_count++;
        end
        full_seen += exp_p.full;
        late_seen += exp_p.late;
      end
    end
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (stall > 0) begin
      out_ready_i <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (out_valid_o && out_ready_i) stall <= $urandom_range(0, 8) * $urandom_range(0, 1);
    end
  end

  task automatic wait_drained();
    while (job_queue.size() > 0 || in_valid_i || placement_queue.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_slots(int unsigned v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    slots_in_use_i <= CfgW'(v);
    clear_forest(v & 9'h1FF);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_job(int unsigned id, int unsigned d);
    job_queue.push_back('{id[JobIdW-1:0], d[DeadlineW-1:0]});
  endtask

  // A phase of random jobs; once the schedule is full, the rest overflow it.
  task automatic random_phase(int n, int unsigned slots);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_job($urandom, 0);
        1: add_job($urandom, $urandom_range(0, 511));
        2: add_job($urandom, slots);
        default: add_job($urandom, $urandom_range(1, slots));
      endcase
    end
    wait_drained();
  endtask

  initial begin
    clear_forest(ResetSlots);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: small schedule, extremes, wrap, deadline zero, full.
    write_slots(4);
    add_job(16'hFFFF, 9'h1FF);
    add_job(0, 0);
    add_job(16'hAAAA, 1);
    add_job(16'h5555, 1);
    add_job(1, 2);
    add_job(2, 3);
    add_job(3, 4);
    wait_drained();
    write_slots(0);
    add_job(7, 0);
    add_job(8, 1);
    add_job(9, 256);
    wait_drained();
    write_slots(9'h1FF);
    add_job(10, 256);
    add_job(11, 256);
    add_job(12, 255);
    add_job(13, 0);
    wait_drained();
    write_slots(1);
    random_phase(6, 1);
    write_slots(2);
    random_phase(8, 2);
    write_slots(16);
    random_phase(60, 16);
    write_slots(7);
    random_phase(40, 7);

    // Long receiver hold-off while jobs keep coming, so input must stall.
    write_slots(40);
    hold_off = 300;
    for (int i = 0; i < 30; i++) add_job($urandom, $urandom_range(1, 40));
    wait_drained();

    write_slots(256);
    random_phase(300, 256);
    write_slots(33);
    random_phase(120, 33);
    write_slots(128);
    random_phase(140, 128);
    stim_done = 1'b1;
    repeat (50) @(posedge clk_i);
    $display("Covered %0d jobs over several slot counts; %0d late, %0d full results.",
             jobs_sent, late_seen, full_seen);
    if (error_count == 0 && placement_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
